>>> rtl/stop_and_wait_arq_sender_core_macros.svh
// Assertion macros for the stop-and-wait ARQ sender core.
`ifndef STOP_AND_WAIT_ARQ_SENDER_CORE_MACROS_SVH
`define STOP_AND_WAIT_ARQ_SENDER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define SAWARQ_CHECK(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset
`define SAWARQ_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SAWARQ_CHECK(lbl, clk, rst_n, ante, cons, msg)
`define SAWARQ_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/sawarq_pkg.sv
// Shared types, codes and constants of the stop-and-wait ARQ sender.
`timescale 1ns / 1ps
package sawarq_pkg;

	localparam int SEQ_MOD_DEF   = 2;
	localparam int MAX_PAYLOAD   = 2048;
	localparam int PAY_SHIFT     = $clog2(MAX_PAYLOAD);
	localparam int IDX_W         = 22;
	localparam int TICK_W        = 33;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	// Request codes
	localparam logic [2:0] REQ_CONNECT    = 3'd0;
	localparam logic [2:0] REQ_START      = 3'd1;
	localparam logic [2:0] REQ_DISCONNECT = 3'd2;
	localparam logic [2:0] REQ_TICK       = 3'd3;
	localparam logic [2:0] REQ_PACKET     = 3'd4;

	// Received flag bit positions
	localparam int FLAG_SYN_BIT = 0;
	localparam int FLAG_ACK_BIT = 1;
	localparam int FLAG_FIN_BIT = 2;

	// Packet kinds
	localparam logic [2:0] KIND_SYN  = 3'd0;
	localparam logic [2:0] KIND_ACK  = 3'd1;
	localparam logic [2:0] KIND_DATA = 3'd2;
	localparam logic [2:0] KIND_END  = 3'd3;
	localparam logic [2:0] KIND_FIN  = 3'd4;

	// Status codes
	localparam logic [2:0] ST_IDLE          = 3'd0;
	localparam logic [2:0] ST_CONNECTING    = 3'd1;
	localparam logic [2:0] ST_CONNECTED     = 3'd2;
	localparam logic [2:0] ST_SENDING       = 3'd3;
	localparam logic [2:0] ST_DONE          = 3'd4;
	localparam logic [2:0] ST_DISCONNECTING = 3'd5;
	localparam logic [2:0] ST_CLOSED        = 3'd6;
	localparam logic [2:0] ST_FAILED        = 3'd7;

	typedef enum logic [11:0] {
		PH_IDLE         = 12'b0000_0000_0001,
		PH_SYN_WAIT     = 12'b0000_0000_0010,
		PH_SYN_LINGER   = 12'b0000_0000_0100,
		PH_CONNECTED    = 12'b0000_0000_1000,
		PH_DATA_WAIT    = 12'b0000_0001_0000,
		PH_END_WAIT     = 12'b0000_0010_0000,
		PH_DONE         = 12'b0000_0100_0000,
		PH_FIN_WAIT_ACK = 12'b0000_1000_0000,
		PH_FIN_WAIT_FIN = 12'b0001_0000_0000,
		PH_FIN_LINGER   = 12'b0010_0000_0000,
		PH_CLOSED       = 12'b0100_0000_0000,
		PH_FAILED       = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] total_length;
		logic [3:0]  rx_flags;
		logic [7:0]  rx_ack;
		logic        rx_checksum_ok;
	} item_t;

	typedef struct packed {
		logic        send_valid;
		logic [2:0]  send_kind;
		logic [7:0]  send_seq;
		logic [20:0] packet_index;
		logic [31:0] byte_offset;
		logic [11:0] data_length;
		logic        retransmit;
		logic [2:0]  status;
	} result_t;

	// Map a phase onto the reported status
	function automatic logic [2:0] status_of(phase_t ph);
		logic [2:0] st;
		unique case (ph)
			PH_IDLE:         st = ST_IDLE;
			PH_SYN_WAIT:     st = ST_CONNECTING;
			PH_SYN_LINGER:   st = ST_CONNECTING;
			PH_CONNECTED:    st = ST_CONNECTED;
			PH_DATA_WAIT:    st = ST_SENDING;
			PH_END_WAIT:     st = ST_SENDING;
			PH_DONE:         st = ST_DONE;
			PH_FIN_WAIT_ACK: st = ST_DISCONNECTING;
			PH_FIN_WAIT_FIN: st = ST_DISCONNECTING;
			PH_FIN_LINGER:   st = ST_DISCONNECTING;
			PH_CLOSED:       st = ST_CLOSED;
			default:         st = ST_FAILED;
		endcase
		return st;
	endfunction

endpackage

>>> rtl/sawarq_fsm.sv
// Connection state machine, transfer counters and result builder of the ARQ sender.
`timescale 1ns / 1ps
module sawarq_fsm import sawarq_pkg::*; #(
	parameter int SEQ_MOD = SEQ_MOD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  item_t       item,
	input  logic [31:0] timeout_ticks,
	output result_t     res
);

	localparam int SEQ_W = $clog2(SEQ_MOD);
	localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_MOD - 1);

	phase_t             phase_q, phase_d;
	logic [SEQ_W-1:0]   next_seq_q, next_seq_d;
	logic [SEQ_W-1:0]   stale_q, stale_d;
	logic [IDX_W-1:0]   cur_idx_q, cur_idx_d;
	logic [IDX_W-1:0]   pkt_cnt_q, pkt_cnt_d;
	logic [31:0]        len_q, len_d;
	logic [TICK_W-1:0]  tick_q, tick_d;

	logic [TICK_W-1:0]  tick_inc;
	logic               to_hit;
	logic               linger_hit;
	logic [IDX_W-1:0]   cnt_calc;
	logic [SEQ_W-1:0]   seq_inc;
	logic [SEQ_W-1:0]   stale_inc;
	logic [SEQ_W-1:0]   seq_prev;
	logic [IDX_W-1:0]   d_idx;
	logic [IDX_W-1:0]   d_cnt;
	logic [31:0]        d_len;
	logic [TICK_W-1:0]  d_off;
	logic [TICK_W-1:0]  d_rem;
	logic [11:0]        d_bytes;
	logic               d_end;
	logic               good;

	// Saturating timer step and its two thresholds
	assign tick_inc   = (tick_q == TICK_MAX) ? tick_q : tick_q + TICK_W'(1);
	assign to_hit     = tick_inc >= TICK_W'(timeout_ticks);
	assign linger_hit = tick_inc > {timeout_ticks, 1'b0};

	// Packet count of a new transfer, rounded up
	assign cnt_calc = IDX_W'((TICK_W'(item.total_length) + TICK_W'(MAX_PAYLOAD - 1)) >> PAY_SHIFT);

	// Sequence arithmetic modulo SEQ_MOD
	assign seq_inc   = (next_seq_q == SEQ_LAST) ? '0 : next_seq_q + SEQ_W'(1);
	assign stale_inc = (stale_q == SEQ_LAST) ? '0 : stale_q + SEQ_W'(1);
	assign seq_prev  = (next_seq_q == '0) ? SEQ_LAST : next_seq_q - SEQ_W'(1);

	assign good = item.rx_checksum_ok;

	// Select the packet that a DATA send would describe
	always_comb begin
		unique case (item.req_type)
			REQ_START: begin
				d_idx = '0;
				d_cnt = cnt_calc;
				d_len = item.total_length;
			end
			REQ_PACKET: begin
				d_idx = cur_idx_q + IDX_W'(1);
				d_cnt = pkt_cnt_q;
				d_len = len_q;
			end
			default: begin
				d_idx = cur_idx_q;
				d_cnt = pkt_cnt_q;
				d_len = len_q;
			end
		endcase
	end

	// Offset and payload size of that packet
	assign d_off   = {d_idx[IDX_W-1-(TICK_W-IDX_W-PAY_SHIFT+PAY_SHIFT-PAY_SHIFT):0],
		{PAY_SHIFT{1'b0}}} ;
	assign d_rem   = TICK_W'(d_len) - d_off;
	assign d_bytes = (d_off >= TICK_W'(d_len)) ? 12'd0 :
		(d_rem > TICK_W'(MAX_PAYLOAD)) ? 12'(MAX_PAYLOAD) : d_rem[11:0];
	assign d_end   = d_idx >= d_cnt;

	// Next state and result for one request
	always_comb begin
		phase_d    = phase_q;
		next_seq_d = next_seq_q;
		stale_d    = stale_q;
		cur_idx_d  = cur_idx_q;
		pkt_cnt_d  = pkt_cnt_q;
		len_d      = len_q;
		tick_d     = tick_q;
		res        = '0;

		unique case (item.req_type)
			REQ_CONNECT: begin
				if (phase_q == PH_IDLE || phase_q == PH_CLOSED || phase_q == PH_FAILED) begin
					next_seq_d     = '0;
					stale_d        = SEQ_W'(1);
					tick_d         = '0;
					phase_d        = PH_SYN_WAIT;
					res.send_valid = 1'b1;
					res.send_kind  = KIND_SYN;
				end
			end
			REQ_START: begin
				if (phase_q == PH_CONNECTED || phase_q == PH_DONE) begin
					len_d          = item.total_length;
					pkt_cnt_d      = cnt_calc;
					cur_idx_d      = '0;
					tick_d         = '0;
					res.send_valid = 1'b1;
					if (d_end) begin
						phase_d       = PH_END_WAIT;
						res.send_kind = KIND_END;
					end else begin
						phase_d          = PH_DATA_WAIT;
						next_seq_d       = seq_inc;
						res.send_kind    = KIND_DATA;
						res.send_seq     = 8'(next_seq_q);
						res.packet_index = d_idx[20:0];
						res.byte_offset  = d_off[31:0];
						res.data_length  = d_bytes;
					end
				end
			end
			REQ_DISCONNECT: begin
				if (phase_q == PH_CONNECTED || phase_q == PH_DONE) begin
					tick_d         = '0;
					phase_d        = PH_FIN_WAIT_ACK;
					res.send_valid = 1'b1;
					res.send_kind  = KIND_FIN;
				end
			end
			REQ_TICK: begin
				unique case (phase_q)
					PH_SYN_WAIT, PH_END_WAIT, PH_FIN_WAIT_ACK: begin
						tick_d = tick_inc;
						if (to_hit) begin
							tick_d         = '0;
							res.send_valid = 1'b1;
							res.retransmit = 1'b1;
							res.send_kind  = (phase_q == PH_SYN_WAIT) ? KIND_SYN :
								(phase_q == PH_END_WAIT) ? KIND_END : KIND_FIN;
						end
					end
					PH_DATA_WAIT: begin
						tick_d = tick_inc;
						if (to_hit) begin
							tick_d           = '0;
							res.send_valid   = 1'b1;
							res.retransmit   = 1'b1;
							res.send_kind    = KIND_DATA;
							res.send_seq     = 8'(seq_prev);
							res.packet_index = d_idx[20:0];
							res.byte_offset  = d_off[31:0];
							res.data_length  = d_bytes;
						end
					end
					PH_SYN_LINGER: begin
						tick_d = tick_inc;
						if (linger_hit)
							phase_d = PH_CONNECTED;
					end
					PH_FIN_LINGER: begin
						tick_d = tick_inc;
						if (linger_hit)
							phase_d = PH_CLOSED;
					end
					default: begin
					end
				endcase
			end
			REQ_PACKET: begin
				unique case (phase_q)
					PH_SYN_WAIT: begin
						if (item.rx_flags[FLAG_ACK_BIT] && good && item.rx_flags[FLAG_SYN_BIT]) begin
							tick_d         = '0;
							phase_d        = PH_SYN_LINGER;
							res.send_valid = 1'b1;
							res.send_kind  = KIND_ACK;
						end else begin
							phase_d = PH_FAILED;
						end
					end
					PH_SYN_LINGER, PH_FIN_LINGER: begin
						tick_d         = '0;
						res.send_valid = 1'b1;
						res.send_kind  = KIND_ACK;
						res.retransmit = 1'b1;
					end
					PH_DATA_WAIT: begin
						if (item.rx_ack != 8'(stale_q) && good) begin
							stale_d        = stale_inc;
							cur_idx_d      = d_idx;
							tick_d         = '0;
							res.send_valid = 1'b1;
							if (d_end) begin
								phase_d       = PH_END_WAIT;
								res.send_kind = KIND_END;
							end else begin
								next_seq_d       = seq_inc;
								res.send_kind    = KIND_DATA;
								res.send_seq     = 8'(next_seq_q);
								res.packet_index = d_idx[20:0];
								res.byte_offset  = d_off[31:0];
								res.data_length  = d_bytes;
							end
						end
					end
					PH_END_WAIT: begin
						phase_d = PH_DONE;
					end
					PH_FIN_WAIT_ACK: begin
						phase_d = (item.rx_flags[FLAG_ACK_BIT] && good) ? PH_FIN_WAIT_FIN : PH_FAILED;
					end
					PH_FIN_WAIT_FIN: begin
						if (item.rx_flags[FLAG_FIN_BIT] && good) begin
							tick_d         = '0;
							phase_d        = PH_FIN_LINGER;
							res.send_valid = 1'b1;
							res.send_kind  = KIND_ACK;
						end else begin
							phase_d = PH_FAILED;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		res.status = status_of(phase_d);
	end

	// Commit state for each processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			next_seq_q <= '0;
			stale_q    <= SEQ_W'(1);
			cur_idx_q  <= '0;
			pkt_cnt_q  <= '0;
			len_q      <= '0;
			tick_q     <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			next_seq_q <= next_seq_d;
			stale_q    <= stale_d;
			cur_idx_q  <= cur_idx_d;
			pkt_cnt_q  <= pkt_cnt_d;
			len_q      <= len_d;
			tick_q     <= tick_d;
		end
	end

endmodule

>>> rtl/stop_and_wait_arq_sender_core.sv
// Top level of the stop-and-wait ARQ sender: request and result registers, timeout register.
//
// Usage: requests (connect, start transfer, disconnect, timer tick, packet
// received) enter on the in channel (in_valid / in_stall) and each one gives
// exactly one result on the out channel (out_valid / out_stall). A result
// says whether a packet must be sent (SYN, ACK, DATA, END or FIN), the
// numbering of a DATA packet, and the link status after the request.
// timeout_ticks is written through cfg_write / cfg_data, by the user only while
// no request is in flight (the block does not enforce this); it resets to 1000.
// A request passes the request register and then the result register
// before its result is on out; a stall on out can hold it between them.
// Throughput: one request per cycle while out_stall holds no result, set by
// the state update between the request register and the result register.
// Reset clears the link to idle, both pipeline registers to empty and the
// timeout to 1000. When the receiver stalls, the result register holds its
// result; one further request is still taken into the request register,
// after which in_stall rises until the result is taken.
`timescale 1ns / 1ps
`include "stop_and_wait_arq_sender_core_macros.svh"
module stop_and_wait_arq_sender_core import sawarq_pkg::*; #(
	parameter int SEQ_MOD = SEQ_MOD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] total_length,
	input  logic [3:0]  rx_flags,
	input  logic [7:0]  rx_ack,
	input  logic        rx_checksum_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        send_valid,
	output logic [2:0]  send_kind,
	output logic [7:0]  send_seq,
	output logic [20:0] packet_index,
	output logic [31:0] byte_offset,
	output logic [11:0] data_length,
	output logic        retransmit,
	output logic [2:0]  status
);

	logic [31:0] timeout_q;
	logic        req_valid_s1;
	item_t       req_s1;
	logic        res_valid_s2;
	result_t     res_s2;
	result_t     res_d;
	logic        advance;

	// Hold the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TIMEOUT_RESET;
		else if (cfg_write)
			timeout_q <= cfg_data;
	end

	// Advance when the result register is empty or being taken
	assign advance  = !res_valid_s2 || !out_stall;
	assign in_stall = req_valid_s1 && !advance;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			req_valid_s1 <= 1'b0;
		else if (!in_stall)
			req_valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.req_type       <= req_type;
			req_s1.total_length   <= total_length;
			req_s1.rx_flags       <= rx_flags;
			req_s1.rx_ack         <= rx_ack;
			req_s1.rx_checksum_ok <= rx_checksum_ok;
		end
	end

	sawarq_fsm #(
		.SEQ_MOD(SEQ_MOD)
	) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (req_valid_s1 && advance),
		.item          (req_s1),
		.timeout_ticks (timeout_q),
		.res           (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_s2 <= 1'b0;
		else if (advance)
			res_valid_s2 <= req_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid_s1)
			res_s2 <= res_d;
	end

	assign out_valid    = res_valid_s2;
	assign send_valid   = res_s2.send_valid;
	assign send_kind    = res_s2.send_kind;
	assign send_seq     = res_s2.send_seq;
	assign packet_index = res_s2.packet_index;
	assign byte_offset  = res_s2.byte_offset;
	assign data_length  = res_s2.data_length;
	assign retransmit   = res_s2.retransmit;
	assign status       = res_s2.status;

	// A request waiting behind a stalled result is kept
	`SAWARQ_CHECK_NEXT(a_req_kept, clk, arst_n, req_valid_s1 && res_valid_s2 && out_stall, req_valid_s1, "request lost behind stalled result")
	// No send means kind, seq, offset, length and retransmit are clear
	`SAWARQ_CHECK(a_idle_fields, clk, arst_n, res_valid_s2 && !res_s2.send_valid, res_s2.send_kind == KIND_SYN && res_s2.send_seq == 8'd0 && res_s2.byte_offset == 32'd0 && res_s2.data_length == 12'd0 && !res_s2.retransmit, "fields set without a send")
	// Only DATA packets carry numbering
	`SAWARQ_CHECK(a_ctrl_fields, clk, arst_n, res_valid_s2 && res_s2.send_valid && res_s2.send_kind != KIND_DATA, res_s2.send_seq == 8'd0 && res_s2.packet_index == 21'd0 && res_s2.byte_offset == 32'd0 && res_s2.data_length == 12'd0, "numbering on a control packet")
	// Payload never exceeds the packet size
	`SAWARQ_CHECK(a_len_max, clk, arst_n, res_valid_s2, res_s2.data_length <= 12'(MAX_PAYLOAD), "payload too long")

endmodule
